// ----- sv/bitset_frame_parity_deframer_top_macros.svh -----
// Assertion macros shared by the deframer checker.
// Depends on a clk and an active-high rst in the scope of each use.
`ifndef BITSET_FRAME_PARITY_DEFRAMER_TOP_MACROS_SVH
`define BITSET_FRAME_PARITY_DEFRAMER_TOP_MACROS_SVH

// Check a property while out of reset
`define BFPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define BFPD_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/bfpd_pkg.sv -----
// Types and constants for the bit-set frame parity deframer.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package bfpd_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'h30;
  localparam logic [7:0] TRAILER_BYTE = 8'hFF;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 27;
  localparam int STATUS_W = 3;

  // Frame decoding phase
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_DATA,
    PH_CHECK,
    PH_TRAILER
  } phase_t;

  // Frame status reported with each result
  typedef enum logic [STATUS_W-1:0] {
    ST_RUN         = 3'd0,
    ST_OK          = 3'd1,
    ST_BAD_HEADER  = 3'd2,
    ST_BAD_CHECK   = 3'd3,
    ST_BAD_TRAILER = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ----- sv/bfpd_in_if.sv -----
// Byte stream channel into the deframer: valid, ready and one byte.
// Depends on bfpd_pkg.
`default_nettype none

interface bfpd_in_if
  import bfpd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/bfpd_out_if.sv -----
// Result channel out of the deframer: valid, ready and the decoded fields.
// Depends on bfpd_pkg.
`default_nettype none

interface bfpd_out_if
  import bfpd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                word_valid;
  logic [WORD_W-1:0]   word_data;
  logic [INDEX_W-1:0]  word_index;
  logic                last_word;
  logic                size_valid;
  logic [WORD_W-1:0]   frame_bits;
  logic [STATUS_W-1:0] frame_status;

  modport source (
    output valid, output word_valid, output word_data, output word_index,
    output last_word, output size_valid, output frame_bits, output frame_status,
    input ready
  );
  modport sink (
    input valid, input word_valid, input word_data, input word_index,
    input last_word, input size_valid, input frame_bits, input frame_status,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/bitset_frame_parity_deframer_top.sv -----
// Each accepted byte's result is loaded into the output register as it is taken.
// Throughput: one byte per cycle if not stalled; the output register takes a new
// result as the held one is taken, so a stall only stops the input while held.
// Reset (rst, synchronous): phase returns to header wait, counters and the
// group check byte clear, and the output register empties.
// Depends on bfpd_pkg, bfpd_in_if and bfpd_out_if.
`default_nettype none

module bitset_frame_parity_deframer_top
  import bfpd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  bfpd_in_if.sink      stream,
  bfpd_out_if.source   result
);

  // Decoder state
  phase_t              phase, phase_next;
  logic [WORD_W-1:0]   bit_total, bit_total_next;
  logic [1:0]          byte_pos, byte_pos_next;
  logic [INDEX_W-1:0]  word_counter, word_counter_next;
  logic [WORD_W-1:0]   word_shift, word_shift_next;
  logic [7:0]          group_parity, group_parity_next;
  logic [INDEX_W-1:0]  last_idx, last_idx_next;
  logic [1:0]          last_nbm1, last_nbm1_next;

  // Result fields for the byte being accepted
  logic                wv, lw, sv;
  logic [WORD_W-1:0]   wd, fb;
  logic [INDEX_W-1:0]  wi;
  status_t             st;

  logic                res_valid;
  logic                take;

  // Helper terms
  logic [WORD_W-1:0]   size_shift;
  logic [WORD_W-1:0]   size_m1;
  logic [WORD_W-1:0]   data_merge;
  logic                is_last;
  logic [1:0]          nb_m1;
  logic                word_done;

  assign stream.ready = !res_valid || result.ready;
  assign take         = stream.valid && stream.ready;

  assign size_shift = {bit_total[WORD_W-BYTE_W-1:0], stream.in_byte};
  assign size_m1    = size_shift - 32'd1;
  assign data_merge = word_shift | (32'(stream.in_byte) << {byte_pos, 3'b000});
  assign is_last    = (word_counter == last_idx);
  assign nb_m1      = is_last ? last_nbm1 : 2'd3;
  assign word_done  = (byte_pos == nb_m1);

  // Next state for one accepted byte
  always_comb begin
    phase_next        = phase;
    bit_total_next    = bit_total;
    byte_pos_next     = byte_pos;
    word_counter_next = word_counter;
    word_shift_next   = word_shift;
    group_parity_next = group_parity;
    last_idx_next     = last_idx;
    last_nbm1_next    = last_nbm1;
    case (phase)
      PH_HEADER: begin
        if (stream.in_byte == HEADER_BYTE) begin
          phase_next     = PH_SIZE;
          bit_total_next = '0;
          byte_pos_next  = '0;
        end
      end
      PH_SIZE: begin
        bit_total_next = size_shift;
        if (byte_pos == 2'd3) begin
          byte_pos_next     = '0;
          word_counter_next = '0;
          word_shift_next   = '0;
          group_parity_next = '0;
          last_idx_next     = size_m1[WORD_W-1:5];
          last_nbm1_next    = size_m1[4:3];
          phase_next        = (size_shift == '0) ? PH_TRAILER : PH_DATA;
        end else begin
          byte_pos_next = byte_pos + 2'd1;
        end
      end
      PH_DATA: begin
        if (word_done) begin
          group_parity_next = group_parity
                            | (8'(^data_merge) << (3'd7 - word_counter[2:0]));
          word_shift_next   = '0;
          byte_pos_next     = '0;
          if (word_counter[2:0] == 3'd7 || is_last) begin
            phase_next = PH_CHECK;
          end else begin
            word_counter_next = word_counter + 27'd1;
          end
        end else begin
          word_shift_next = data_merge;
          byte_pos_next   = byte_pos + 2'd1;
        end
      end
      PH_CHECK: begin
        group_parity_next = '0;
        if (stream.in_byte != group_parity) begin
          phase_next = PH_HEADER;
        end else if (is_last) begin
          phase_next = PH_TRAILER;
        end else begin
          word_counter_next = word_counter + 27'd1;
          phase_next        = PH_DATA;
        end
      end
      PH_TRAILER: begin
        phase_next = PH_HEADER;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  // Result fields for one accepted byte
  always_comb begin
    wv = 1'b0;
    wd = '0;
    wi = '0;
    lw = 1'b0;
    sv = 1'b0;
    fb = '0;
    st = ST_RUN;
    case (phase)
      PH_HEADER: begin
        if (stream.in_byte != HEADER_BYTE) st = ST_BAD_HEADER;
      end
      PH_SIZE: begin
        if (byte_pos == 2'd3) begin
          sv = 1'b1;
          fb = size_shift;
        end
      end
      PH_DATA: begin
        if (word_done) begin
          wv = 1'b1;
          wd = data_merge;
          wi = word_counter;
          lw = is_last;
        end
      end
      PH_CHECK: begin
        if (stream.in_byte != group_parity) st = ST_BAD_CHECK;
      end
      PH_TRAILER: begin
        st = (stream.in_byte == TRAILER_BYTE) ? ST_OK : ST_BAD_TRAILER;
      end
      default: begin
        st = ST_RUN;
      end
    endcase
  end

  // Advance decoder state on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      bit_total    <= '0;
      byte_pos     <= '0;
      word_counter <= '0;
      word_shift   <= '0;
      group_parity <= '0;
      last_idx     <= '0;
      last_nbm1    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      bit_total    <= bit_total_next;
      byte_pos     <= byte_pos_next;
      word_counter <= word_counter_next;
      word_shift   <= word_shift_next;
      group_parity <= group_parity_next;
      last_idx     <= last_idx_next;
      last_nbm1    <= last_nbm1_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.word_valid   <= wv;
      result.word_data    <= wd;
      result.word_index   <= wi;
      result.last_word    <= lw;
      result.size_valid   <= sv;
      result.frame_bits   <= fb;
      result.frame_status <= st;
    end
  end

  assign result.valid = res_valid;

endmodule

`default_nettype wire

// ----- sv/bfpd_checker.sv -----
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on bfpd_pkg and bitset_frame_parity_deframer_top_macros.svh.
`default_nettype none

`include "bitset_frame_parity_deframer_top_macros.svh"

module bfpd_checker
  import bfpd_pkg::*;
(
  input wire                clk,
  input wire                rst,
  input wire                res_valid,
  input wire                res_ready,
  input wire                word_valid,
  input wire [WORD_W-1:0]   word_data,
  input wire [INDEX_W-1:0]  word_index,
  input wire                last_word,
  input wire                size_valid,
  input wire [STATUS_W-1:0] frame_status
);

  // A stalled result stays offered
  `BFPD_ASSERT(a_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

  // No result is offered on the cycle after a reset cycle
  `BFPD_ASSERT_ANY(a_rst, rst |=> !res_valid, "result offered after reset")

  // Word fields are zero unless a word is emitted
  `BFPD_ASSERT(a_idle_word, res_valid && !word_valid |-> word_data == '0 && word_index == '0 && !last_word, "word fields set without a word")

  // A size report is mid-frame and carries no word
  `BFPD_ASSERT(a_size, res_valid && size_valid |-> !word_valid && frame_status == ST_RUN, "size report overlaps word or status")

endmodule

bind bitset_frame_parity_deframer_top bfpd_checker u_bfpd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .word_valid   (result.word_valid),
  .word_data    (result.word_data),
  .word_index   (result.word_index),
  .last_word    (result.last_word),
  .size_valid   (result.size_valid),
  .frame_status (result.frame_status)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for bitset_frame_parity_deframer_top: framed byte streams in,
// decoded words and frame status out, each result checked against an in-bench predictor.
// Depends on bfpd_pkg, bfpd_in_if, bfpd_out_if and the deframer top level.
`timescale 1ns / 100ps

module testbench
  import bfpd_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1050;

  // Kinds of generated byte sequences
  typedef enum int {
    FRM_GOOD,
    FRM_BAD_CHECK,
    FRM_BAD_TRAILER,
    FRM_HUGE_ABORT,
    FRM_NOISE
  } frame_kind_t;

  // Receiver stall behaviors
  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN,
    RX_CHOKE
  } stall_mode_t;

  typedef struct packed {
    logic               word_valid;
    logic [WORD_W-1:0]  word_data;
    logic [INDEX_W-1:0] word_index;
    logic               last_word;
    logic               size_valid;
    logic [WORD_W-1:0]  frame_bits;
    status_t            frame_status;
  } deframe_res_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    bit                drain;
  } stream_byte_t;

  logic clk;
  logic rst;

  bfpd_in_if  stream_if ();
  bfpd_out_if result_if ();

  bitset_frame_parity_deframer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  stream_byte_t pend_q[$];
  deframe_res_t exp_q[$];
  int           err_cnt;
  int           cycle_cnt;

  // Predictor state
  phase_t             ph;
  logic [WORD_W-1:0]  bits_total;
  logic [1:0]         byte_pos;
  logic [INDEX_W-1:0] word_idx;
  logic [WORD_W-1:0]  word_acc;
  logic [7:0]         chk_acc;

  // Driver pacing
  int burst_left;
  int gap_left;

  // Receiver pacing
  stall_mode_t stall_mode;
  int          stall_span;
  logic [7:0]  stall_pat;
  logic [2:0]  pat_pos;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the deframer state by one byte and return the result it yields
  function automatic deframe_res_t deframe_step(input logic [BYTE_W-1:0] b);
    deframe_res_t       r;
    logic [WORD_W-1:0]  tail;
    logic [INDEX_W-1:0] last_idx;
    logic               is_last;
    logic [2:0]         nbytes;
    r = '0;
    r.frame_status = ST_RUN;
    tail = bits_total - 32'd1;
    last_idx = tail[WORD_W-1:5];
    case (ph)
      PH_HEADER: begin
        if (b == HEADER_BYTE) begin
          ph = PH_SIZE;
          bits_total = '0;
          byte_pos = '0;
        end else begin
          r.frame_status = ST_BAD_HEADER;
        end
      end
      PH_SIZE: begin
        bits_total = {bits_total[23:0], b};
        if (byte_pos == 2'd3) begin
          r.size_valid = 1'b1;
          r.frame_bits = bits_total;
          byte_pos = '0;
          word_idx = '0;
          word_acc = '0;
          chk_acc = '0;
          ph = (bits_total == '0) ? PH_TRAILER : PH_DATA;
        end else begin
          byte_pos = byte_pos + 2'd1;
        end
      end
      PH_DATA: begin
        is_last = (word_idx == last_idx);
        nbytes = is_last ? ({1'b0, tail[4:3]} + 3'd1) : 3'd4;
        word_acc = word_acc | (32'(b) << (8 * byte_pos));
        if ({1'b0, byte_pos} + 3'd1 >= nbytes) begin
          r.word_valid = 1'b1;
          r.word_data = word_acc;
          r.word_index = word_idx;
          r.last_word = is_last;
          chk_acc[3'd7 - word_idx[2:0]] = chk_acc[3'd7 - word_idx[2:0]] | (^word_acc);
          word_acc = '0;
          byte_pos = '0;
          if (word_idx[2:0] == 3'd7 || is_last) begin
            ph = PH_CHECK;
          end else begin
            word_idx = word_idx + 1'b1;
          end
        end else begin
          byte_pos = byte_pos + 2'd1;
        end
      end
      PH_CHECK: begin
        if (b != chk_acc) begin
          r.frame_status = ST_BAD_CHECK;
          ph = PH_HEADER;
        end else if (word_idx == last_idx) begin
          ph = PH_TRAILER;
        end else begin
          word_idx = word_idx + 1'b1;
          ph = PH_DATA;
        end
        chk_acc = '0;
      end
      default: begin
        r.frame_status = (b == TRAILER_BYTE) ? ST_OK : ST_BAD_TRAILER;
        ph = PH_HEADER;
      end
    endcase
    return r;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input bit drain);
    stream_byte_t e;
    e.data = b;
    e.drain = drain;
    pend_q.push_back(e);
  endtask

  // Queue one frame; a bad check byte ends the frame where it stands
  task automatic add_frame(input logic [WORD_W-1:0] nbits, input frame_kind_t kind,
                           input bit drain);
    longint unsigned nwords;
    longint unsigned ngroups;
    longint unsigned idx;
    longint          bad_grp;
    logic [WORD_W-1:0] tail;
    logic [WORD_W-1:0] w;
    logic [7:0]        chk;
    logic [7:0]        trl;
    int                nb;
    int                grp_words;
    tail = nbits - 32'd1;
    nwords = (nbits == '0) ? 0 : longint'(tail[WORD_W-1:5]) + 1;
    ngroups = (nwords + 7) / 8;
    bad_grp = -1;
    if ((kind == FRM_BAD_CHECK || kind == FRM_HUGE_ABORT) && ngroups > 0)
      bad_grp = $urandom_range(0, (ngroups > 3) ? 2 : int'(ngroups) - 1);
    push_byte(HEADER_BYTE, drain);
    for (int i = 3; i >= 0; i--) push_byte(nbits[8*i +: 8], 1'b0);
    for (longint unsigned g = 0; g < ngroups; g++) begin
      chk = '0;
      grp_words = (nwords - 8 * g > 8) ? 8 : int'(nwords - 8 * g);
      for (int k = 0; k < grp_words; k++) begin
        idx = 8 * g + k;
        nb = (idx == nwords - 1) ? int'(tail[4:3]) + 1 : 4;
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = '1;
          default: w = $urandom;
        endcase
        w = w & (32'hFFFF_FFFF >> (8 * (4 - nb)));
        for (int j = 0; j < nb; j++) push_byte(w[8*j +: 8], 1'b0);
        chk[7 - k] = ^w;
      end
      if (longint'(g) == bad_grp) begin
        push_byte(chk ^ 8'($urandom_range(1, 255)), 1'b0);
        return;
      end
      push_byte(chk, 1'b0);
    end
    if (kind == FRM_BAD_TRAILER) begin
      trl = 8'($urandom_range(0, 254));
      push_byte(trl, 1'b0);
    end else begin
      push_byte(TRAILER_BYTE, 1'b0);
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_bits();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(1, 64);
      4, 5, 6:    return $urandom_range(65, 400);
      7:          return $urandom_range(401, 1100);
      8:          return 256 * $urandom_range(1, 4);
      default:    return 32 * $urandom_range(1, 20) + $urandom_range(0, 1);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Stimulus, then wait for the block to drain and report
  initial begin
    int          pick;
    int          n;
    bit          first;
    bit          drain;
    logic [7:0]  b;
    logic [31:0] nbits;
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.in_byte = '0;
    result_if.ready = 1'b0;
    err_cnt = 0;

    // Directed: header extremes, empty frames, single bit, maximum bit count
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h31, 1'b0);
    add_frame(32'd0, FRM_GOOD, 1'b0);
    add_frame(32'd0, FRM_BAD_TRAILER, 1'b0);
    add_frame(32'd1, FRM_GOOD, 1'b0);
    add_frame(32'hFFFF_FFFF, FRM_HUGE_ABORT, 1'b0);

    // Random: mostly well-formed frames, some broken ones and noise
    first = 1'b1;
    while (pend_q.size() < ITEM_TARGET) begin
      drain = first || ($urandom_range(0, 15) == 0);
      first = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_frame(pick_bits(), FRM_GOOD, drain);
      end else if (pick < 77) begin
        add_frame(pick_bits(), FRM_BAD_CHECK, drain);
      end else if (pick < 87) begin
        add_frame(($urandom_range(0, 5) == 0) ? 32'd0 : pick_bits(), FRM_BAD_TRAILER, drain);
      end else if (pick < 93) begin
        nbits = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0100_0000);
        add_frame(nbits, FRM_HUGE_ABORT, drain);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == HEADER_BYTE) b = 8'h31;
          push_byte(b, drain && i == 0);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || stream_if.valid || exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Drive bytes in bursts; predict each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
      stream_if.in_byte <= '0;
      ph = PH_HEADER;
      bits_total = '0;
      byte_pos = '0;
      word_idx = '0;
      word_acc = '0;
      chk_acc = '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (stream_if.valid && stream_if.ready)
        exp_q.push_back(deframe_step(stream_if.in_byte));
      if (!stream_if.valid || stream_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          stream_if.valid <= 1'b0;
        end else if (pend_q.size() != 0 && !(pend_q[0].drain && exp_q.size() != 0)) begin
          stream_if.valid <= 1'b1;
          stream_if.in_byte <= pend_q[0].data;
          void'(pend_q.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel; switch the stall behavior every so often
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_mode = RX_OPEN;
      stall_span = 0;
      stall_pat = 8'h01;
      pat_pos = '0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(32, 160);
        stall_pat = 8'($urandom) | 8'h01;
      end else begin
        stall_span--;
      end
      case (stall_mode)
        RX_OPEN:    result_if.ready <= 1'b1;
        RX_RANDOM:  result_if.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: result_if.ready <= stall_pat[pat_pos];
        default:    result_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
      pat_pos = pat_pos + 3'd1;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    deframe_res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (exp_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        check_field("word_valid", want.word_valid, result_if.word_valid);
        check_field("word_data", want.word_data, result_if.word_data);
        check_field("word_index", want.word_index, result_if.word_index);
        check_field("last_word", want.last_word, result_if.last_word);
        check_field("size_valid", want.size_valid, result_if.size_valid);
        check_field("frame_bits", want.frame_bits, result_if.frame_bits);
        check_field("frame_status", want.frame_status, result_if.frame_status);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
